FILE: src/ugnq_pkg.sv
// ----------------------------------------------------------------------------
// ugnq_pkg: shared types for the uniform grid neighbour query block
// Request and result word layouts, request codes, status codes and states.
// ----------------------------------------------------------------------------
package ugnq_pkg;

    localparam logic [1:0] REQ_CLEAR    = 2'd0;
    localparam logic [1:0] REQ_INSERT   = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_OUTSIDE   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam logic [0:0] REG_COLUMNS = 1'd0;
    localparam logic [0:0] REG_ROWS    = 1'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] radius;
        logic [31:0] entity_id;
        logic [15:0] type_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] agent_id;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_INS_RD,
        S_INS_WR,
        S_Q_CELL,
        S_Q_FILL,
        S_Q_SLOT,
        S_Q_CHECK,
        S_Q_END
    } t_state;

endpackage

FILE: src/ugnq_div.sv
// ----------------------------------------------------------------------------
// ugnq_div: reciprocal divider by a constant cell size
// Divides a 17-bit unsigned value by multiplying with a scaled reciprocal.
// ----------------------------------------------------------------------------
module ugnq_div #(
    parameter int DIVISOR = 100
) (
    input  logic [16:0] i_dividend,
    output logic [16:0] o_quotient
);
    // With the shift at 17 plus the ceiling of the divisor's log2, the rounding error of
    // the reciprocal stays below one for every 17-bit dividend.
    localparam int SH = 17 + $clog2(DIVISOR);
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [35:0] w_prod;

    assign w_prod     = 36'(i_dividend) * 36'(RECIP);
    assign o_quotient = 17'(w_prod >> SH);
endmodule

FILE: src/uniform_grid_neighbor_query_top.sv
// ----------------------------------------------------------------------------
// uniform_grid_neighbor_query_top: uniform grid spatial bucketing with queries
// Files entity ids into grid cells and walks covered cells for range queries.
// ----------------------------------------------------------------------------
//  Channel   Handshake                        Word
//  request   start high while busy is low     i_req  (t_req)
//  result    o_valid for one cycle, no stall  o_res  (t_res)
//  config    APB write, pready always high    num_columns at 0, num_rows at 4
//
// One request is in flight at a time; busy falls as its final word is shown.
// Cell coordinates come from a combinational reciprocal multiply, one per cycle.
// An insert divides x and y, reads the fill and writes the id; outside, it answers
// at the read. A query divides four bounds, sets up, reads each covered cell's fill
// and each stored id, checks it, then ends. A clear, and the sweep after reset (no
// word), clears one cell a cycle over MAX_COLS*MAX_ROWS. The receiver cannot stall.
module uniform_grid_neighbor_query_top #(
    parameter int CELL_SIZE  = 100,
    parameter int MAX_COLS   = 16,
    parameter int MAX_ROWS   = 16,
    parameter int CELL_SLOTS = 8,
    parameter int MAX_HITS   = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ugnq_pkg::t_req       i_req,
    output logic                 o_valid,
    output ugnq_pkg::t_res       o_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NC  = MAX_COLS * MAX_ROWS;
    localparam int AW  = $clog2(NC) + 1;
    localparam int SW  = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
    localparam int FW  = $clog2(CELL_SLOTS + 1);
    localparam int HW  = $clog2(MAX_HITS + 1);

    // Configuration registers.
    logic [4:0] r_cols, r_rows;
    logic       w_wr;
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 5'd16;
            r_rows <= 5'd16;
        end else if (w_wr && paddr[2] == ugnq_pkg::REG_COLUMNS) begin
            r_cols <= pwdata[4:0];
        end else if (w_wr && paddr[2] == ugnq_pkg::REG_ROWS) begin
            r_rows <= pwdata[4:0];
        end
    end
    assign prdata = {27'd0, paddr[2] ? r_rows : r_cols};

    // Grid in use, clamped to the built size.
    logic [6:0] w_gc, w_gr;
    assign w_gc = ({2'd0, r_cols} < 7'(MAX_COLS)) ? {2'd0, r_cols} : 7'(MAX_COLS);
    assign w_gr = ({2'd0, r_rows} < 7'(MAX_ROWS)) ? {2'd0, r_rows} : 7'(MAX_ROWS);

    // Memories.
    logic [FW-1:0] m_fill [NC];
    logic [31:0]   m_slot [NC*CELL_SLOTS];
    logic [FW-1:0] r_fill_q;
    logic [31:0]   r_slot_q;

    ugnq_pkg::t_state r_st, n_st;
    ugnq_pkg::t_req   r_req;
    logic [1:0]  r_di;           // which divide: 0 x-lo/x, 1 x-hi, 2 y-lo/y, 3 y-hi
    logic [16:0] r_q [4];
    logic [AW-1:0] r_clr;
    logic [6:0]  r_x, r_y;
    logic [FW-1:0] r_s;
    logic [FW-1:0] r_f;
    logic [HW-1:0] r_n;
    logic        r_pend;
    ugnq_pkg::t_res r_hold;

    // Divider.
    logic [16:0] w_dnum, w_dq;
    ugnq_div #(.DIVISOR(CELL_SIZE)) u_div (
        .i_dividend(w_dnum), .o_quotient(w_dq)
    );

    logic [16:0] w_px, w_py, w_rd;
    assign w_px = {1'b0, r_req.pos_x};
    assign w_py = {1'b0, r_req.pos_y};
    assign w_rd = {1'b0, r_req.radius};
    always_comb begin
        unique case (r_di)
            2'd0: w_dnum = (r_req.req_type == ugnq_pkg::REQ_INSERT) ? w_px :
                           ((w_px > w_rd) ? w_px - w_rd : 17'd0);
            2'd1: w_dnum = w_px + w_rd;
            2'd2: w_dnum = (r_req.req_type == ugnq_pkg::REQ_INSERT) ? w_py :
                           ((w_py > w_rd) ? w_py - w_rd : 17'd0);
            default: w_dnum = w_py + w_rd;
        endcase
    end

    // Query rectangle after clamping.
    logic [16:0] w_xhi, w_yhi;
    logic        w_empty;
    assign w_xhi = (r_q[1] > 17'(w_gc) - 17'd1) ? 17'(w_gc) - 17'd1 : r_q[1];
    assign w_yhi = (r_q[3] > 17'(w_gr) - 17'd1) ? 17'(w_gr) - 17'd1 : r_q[3];
    assign w_empty = (w_gc == 7'd0) || (w_gr == 7'd0) || (r_q[0] > w_xhi) || (r_q[2] > w_yhi);

    logic [AW-2:0] w_cell;
    assign w_cell = (AW-1)'(r_y[RW-1:0] * MAX_COLS) + (AW-1)'(r_x[CW-1:0]);
    logic [AW-2:0] w_icell;
    assign w_icell = (AW-1)'(r_q[2][RW-1:0] * MAX_COLS) + (AW-1)'(r_q[0][CW-1:0]);
    logic w_out;
    assign w_out = (r_q[0] >= 17'(w_gc)) || (r_q[2] >= 17'(w_gr));
    logic [FW-1:0] w_fclip;
    assign w_fclip = (r_fill_q > FW'(CELL_SLOTS)) ? FW'(CELL_SLOTS) : r_fill_q;
    logic w_match;
    assign w_match = r_slot_q[31:16] == r_req.type_id;
    logic w_lastcell;
    assign w_lastcell = (17'(r_x) == w_xhi) && (17'(r_y) == w_yhi);

    // The fill seen in Q_SLOT with the slot index at zero is the one just read
    // for the current cell; later steps use the copy taken then.
    logic [FW-1:0] w_flim;
    assign w_flim = (r_s == '0) ? w_fclip : r_f;
    logic w_rdslot;
    assign w_rdslot = (r_st == ugnq_pkg::S_Q_SLOT) && (r_s < w_flim);

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ugnq_pkg::S_IDLE: begin
                if (start) begin
                    priority case (i_req.req_type)
                        ugnq_pkg::REQ_CLEAR:  n_st = ugnq_pkg::S_CLEAR;
                        ugnq_pkg::REQ_INSERT: n_st = ugnq_pkg::S_DIV;
                        ugnq_pkg::REQ_QUERY:  n_st = ugnq_pkg::S_DIV;
                        default:              n_st = ugnq_pkg::S_IDLE;
                    endcase
                end
            end
            ugnq_pkg::S_CLEAR:
                if (r_clr == AW'(NC - 1)) n_st = ugnq_pkg::S_IDLE;
            ugnq_pkg::S_DIV:
                if (r_di == 2'd3) begin
                    n_st = (r_req.req_type == ugnq_pkg::REQ_INSERT) ? ugnq_pkg::S_INS_RD
                                                                   : ugnq_pkg::S_Q_CELL;
                end
            ugnq_pkg::S_INS_RD: n_st = w_out ? ugnq_pkg::S_IDLE : ugnq_pkg::S_INS_WR;
            ugnq_pkg::S_INS_WR: n_st = ugnq_pkg::S_IDLE;
            ugnq_pkg::S_Q_CELL: n_st = w_empty ? ugnq_pkg::S_Q_END : ugnq_pkg::S_Q_FILL;
            ugnq_pkg::S_Q_FILL: n_st = ugnq_pkg::S_Q_SLOT;
            ugnq_pkg::S_Q_SLOT: n_st = ugnq_pkg::S_Q_CHECK;
            ugnq_pkg::S_Q_CHECK: n_st = ugnq_pkg::S_Q_SLOT;
            ugnq_pkg::S_Q_END: n_st = ugnq_pkg::S_IDLE;
            default: n_st = ugnq_pkg::S_IDLE;
        endcase
        // Slot walk: at Q_SLOT, the slot read is issued unless the cell is done.
        if (r_st == ugnq_pkg::S_Q_SLOT && r_s >= w_flim) begin
            n_st = w_lastcell ? ugnq_pkg::S_Q_END : ugnq_pkg::S_Q_FILL;
        end
        if (r_st == ugnq_pkg::S_Q_CHECK && w_match && r_n == HW'(MAX_HITS)) begin
            n_st = ugnq_pkg::S_Q_END;
        end
    end

    // Outputs of the control.
    assign busy = (r_st != ugnq_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ugnq_pkg::S_CLEAR;
            r_clr  <= '0;
            o_valid <= 1'b0;
            r_pend <= 1'b0;
            r_di   <= '0;
        end else begin
            r_st    <= n_st;
            o_valid <= 1'b0;
            unique case (r_st)
                ugnq_pkg::S_IDLE: begin
                    r_clr  <= '0;
                    r_di   <= 2'd0;
                    r_pend <= 1'b0;
                    r_n    <= '0;
                end
                ugnq_pkg::S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NC - 1) && r_pend) begin
                        o_valid <= 1'b1;
                        o_res   <= '{status: ugnq_pkg::ST_OK, found: 1'b0, agent_id: '0,
                                     last: 1'b1};
                    end
                end
                ugnq_pkg::S_DIV: begin
                    r_q[r_di] <= w_dq;
                    r_di <= (r_req.req_type == ugnq_pkg::REQ_INSERT && r_di == 2'd0) ? 2'd2 :
                            (r_req.req_type == ugnq_pkg::REQ_INSERT && r_di == 2'd2) ? 2'd3 :
                            r_di + 2'd1;
                end
                ugnq_pkg::S_INS_RD: begin
                    if (w_out) begin
                        o_valid <= 1'b1;
                        o_res <= '{status: ugnq_pkg::ST_OUTSIDE, found: 1'b0, agent_id: '0,
                                   last: 1'b1};
                    end
                end
                ugnq_pkg::S_INS_WR: begin
                    o_valid <= 1'b1;
                    o_res <= '{status: (r_fill_q >= FW'(CELL_SLOTS)) ? ugnq_pkg::ST_FULL
                                                                      : ugnq_pkg::ST_OK,
                               found: 1'b0, agent_id: '0, last: 1'b1};
                end
                ugnq_pkg::S_Q_CELL: begin
                    r_x <= r_q[0][6:0];
                    r_y <= r_q[2][6:0];
                end
                ugnq_pkg::S_Q_FILL: begin
                    r_s <= '0;
                end
                ugnq_pkg::S_Q_SLOT: begin
                    if (r_s == '0) r_f <= w_fclip;
                    if ((r_s == '0 ? w_fclip : r_f) <= r_s || (r_s != '0 && r_s >= r_f)) begin
                        if (17'(r_x) == w_xhi) begin
                            r_x <= r_q[0][6:0];
                            r_y <= r_y + 7'd1;
                        end else begin
                            r_x <= r_x + 7'd1;
                        end
                    end
                end
                ugnq_pkg::S_Q_CHECK: begin
                    r_s <= r_s + FW'(1);
                    if (w_match) begin
                        if (r_n == HW'(MAX_HITS)) begin
                            r_hold.status <= ugnq_pkg::ST_TRUNCATED;
                        end else begin
                            if (r_pend) begin
                                o_valid <= 1'b1;
                                o_res   <= r_hold;
                            end
                            r_pend <= 1'b1;
                            r_n    <= r_n + HW'(1);
                            r_hold <= '{status: ugnq_pkg::ST_OK, found: 1'b1,
                                        agent_id: r_slot_q, last: 1'b0};
                        end
                    end
                end
                ugnq_pkg::S_Q_END: begin
                    o_valid <= 1'b1;
                    if (r_pend) begin
                        o_res <= '{status: r_hold.status, found: 1'b1,
                                   agent_id: r_hold.agent_id, last: 1'b1};
                    end else begin
                        o_res <= '{status: ugnq_pkg::ST_OK, found: 1'b0, agent_id: '0,
                                   last: 1'b1};
                    end
                end
                default: ;
            endcase
            if (r_st == ugnq_pkg::S_IDLE && start && i_req.req_type == ugnq_pkg::REQ_CLEAR) begin
                r_pend <= 1'b1;
            end
        end
        if (r_st == ugnq_pkg::S_IDLE && start) begin
            r_req <= i_req;
        end
    end

    // Fill memory: registered read, write back on insert (when not full) or clear.
    always_ff @(posedge i_clk) begin
        if (r_st == ugnq_pkg::S_CLEAR) begin
            m_fill[r_clr[AW-2:0]] <= '0;
        end else if (r_st == ugnq_pkg::S_INS_WR && r_fill_q < FW'(CELL_SLOTS)) begin
            m_fill[w_icell] <= r_fill_q + FW'(1);
        end
        r_fill_q <= m_fill[(r_st == ugnq_pkg::S_Q_FILL) ? w_cell : w_icell];
    end

    // Slot memory.
    logic [AW+SW-2:0] w_saddr;
    always_comb begin
        if (r_st == ugnq_pkg::S_INS_WR) begin
            w_saddr = (AW+SW-1)'(w_icell) * (AW+SW-1)'(CELL_SLOTS) +
                      (AW+SW-1)'(r_fill_q[FW-1:0]);
        end else begin
            w_saddr = (AW+SW-1)'(w_cell) * (AW+SW-1)'(CELL_SLOTS) + (AW+SW-1)'(r_s);
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_st == ugnq_pkg::S_INS_WR && r_fill_q < FW'(CELL_SLOTS)) begin
            m_slot[w_saddr] <= r_req.entity_id;
        end
        if (w_rdslot) begin
            r_slot_q <= m_slot[w_saddr];
        end
    end
endmodule

FILE: verif/tb_uniform_grid_neighbor_query_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uniform_grid_neighbor_query_top: self-checking bench for the grid query
// Requests go in from a queue, a behavioural grid model predicts every result
// word, and the monitor compares each word shown by the block in order.
// ----------------------------------------------------------------------------
module tb_uniform_grid_neighbor_query_top;

    localparam int CELL_SIZE  = 100;
    localparam int MAX_COLS   = 16;
    localparam int MAX_ROWS   = 16;
    localparam int CELL_SLOTS = 8;
    localparam int MAX_HITS   = 64;
    // Cycles allowed after the last word before the block is taken as quiet.
    // This covers a reserved request still being dropped and a clear sweep.
    localparam int SETTLE     = 400;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    ugnq_pkg::t_req i_req;
    logic           o_valid;
    ugnq_pkg::t_res o_res;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    uniform_grid_neighbor_query_top #(
        .CELL_SIZE(CELL_SIZE), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS),
        .CELL_SLOTS(CELL_SLOTS), .MAX_HITS(MAX_HITS)
    ) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_res(o_res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The clock: 20 ns period, high then low.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Model state of the grid: per-cell fill counts, the stored ids and the
    // two size registers as last written.
    logic [3:0]  grid_fill [MAX_COLS*MAX_ROWS];
    logic [31:0] grid_slot [MAX_COLS*MAX_ROWS*CELL_SLOTS];
    logic [4:0]  cfg_cols;
    logic [4:0]  cfg_rows;

    ugnq_pkg::t_req pending_reqs[$];   // requests waiting to be offered to the block
    ugnq_pkg::t_res expected_words[$]; // result words predicted but not yet seen
    int   mismatches;
    int   idle_pct;          // chance in a hundred that the sender idles

    function automatic void add_req(input ugnq_pkg::t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void add_word(input ugnq_pkg::t_res w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    // Covered cell range along one axis, clamped to the grid in use.
    function automatic void axis_span(input int unsigned centre, input int unsigned rad,
                                      input int unsigned lim, output int unsigned lo,
                                      output int unsigned hi, inout bit none);
        lo = (centre > rad) ? (centre - rad) / CELL_SIZE : 0;
        hi = (centre + rad) / CELL_SIZE;
        if (lim == 0) begin
            none = 1'b1;
        end else begin
            if (hi > lim - 1) hi = lim - 1;
            if (lo > hi) none = 1'b1;
        end
    endfunction

    function automatic ugnq_pkg::t_res make_word(logic [1:0] st, logic fnd,
                                                 logic [31:0] id, logic lst);
        ugnq_pkg::t_res w;
        w.status   = st;
        w.found    = fnd;
        w.agent_id = id;
        w.last     = lst;
        return w;
    endfunction

    // Applies one accepted request to the grid model and queues its words.
    task automatic predict_request(input ugnq_pkg::t_req r);
        int unsigned    cols, rows, c, rw, cell_idx, x0, x1, y0, y1, n, fill, tail;
        bit             none, cut;
        ugnq_pkg::t_res w;
        cols = (cfg_cols < MAX_COLS) ? cfg_cols : MAX_COLS;
        rows = (cfg_rows < MAX_ROWS) ? cfg_rows : MAX_ROWS;
        none = 1'b0;
        cut  = 1'b0;
        n    = 0;
        case (r.req_type)
            ugnq_pkg::REQ_CLEAR: begin
                foreach (grid_fill[i]) grid_fill[i] = '0;
                add_word(make_word(ugnq_pkg::ST_OK, 1'b0, '0, 1'b1));
            end
            ugnq_pkg::REQ_INSERT: begin
                c  = r.pos_x / CELL_SIZE;
                rw = r.pos_y / CELL_SIZE;
                if (c >= cols || rw >= rows) begin
                    add_word(make_word(ugnq_pkg::ST_OUTSIDE, 1'b0, '0, 1'b1));
                end else begin
                    cell_idx = rw * MAX_COLS + c;
                    if (grid_fill[cell_idx] >= CELL_SLOTS) begin
                        add_word(make_word(ugnq_pkg::ST_FULL, 1'b0, '0, 1'b1));
                    end else begin
                        grid_slot[cell_idx*CELL_SLOTS + grid_fill[cell_idx]] = r.entity_id;
                        grid_fill[cell_idx] = grid_fill[cell_idx] + 4'd1;
                        add_word(make_word(ugnq_pkg::ST_OK, 1'b0, '0, 1'b1));
                    end
                end
            end
            ugnq_pkg::REQ_QUERY: begin
                axis_span(r.pos_x, r.radius, cols, x0, x1, none);
                axis_span(r.pos_y, r.radius, rows, y0, y1, none);
                if (!none) begin
                    for (int unsigned y = y0; y <= y1 && !cut; y++) begin
                        for (int unsigned x = x0; x <= x1 && !cut; x++) begin
                            cell_idx = y * MAX_COLS + x;
                            fill = (grid_fill[cell_idx] > CELL_SLOTS) ? CELL_SLOTS
                                                                      : grid_fill[cell_idx];
                            for (int unsigned s = 0; s < fill; s++) begin
                                if (grid_slot[cell_idx*CELL_SLOTS + s][31:16] == r.type_id)
                                begin
                                    if (n >= MAX_HITS) begin
                                        cut = 1'b1;
                                        break;
                                    end
                                    add_word(make_word(ugnq_pkg::ST_OK, 1'b1,
                                        grid_slot[cell_idx*CELL_SLOTS + s], 1'b0));
                                    n++;
                                end
                            end
                        end
                    end
                end
                if (n == 0) begin
                    add_word(make_word(ugnq_pkg::ST_OK, 1'b0, '0, 1'b1));
                end else begin
                    tail = expected_words.size() - 1;
                    w = expected_words[tail];
                    w.last = 1'b1;
                    if (cut) w.status = ugnq_pkg::ST_TRUNCATED;
                    expected_words[tail] = w;
                end
            end
            default: ; // reserved code: the block drops it without a word
        endcase
    endtask

    // Driver: offers the head of the queue; start stays high until the word
    // is taken at an edge where busy is low, and the model follows at once.
    always @(posedge i_clk) begin
        ugnq_pkg::t_req nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else begin
            if (start && !busy) predict_request(i_req);
            if (!start || !busy) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    i_req <= nxt;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed word is held against the oldest expectation.
    always @(posedge i_clk) begin
        ugnq_pkg::t_res want;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d found %0b id %h last %0b",
                             o_res.status, o_res.found, o_res.agent_id, o_res.last);
            end else begin
                want = expected_words.pop_front();
                if (o_res !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected st %0d f %0b id %h l %0b,",
                                  " got st %0d f %0b id %h l %0b"},
                                 want.status, want.found, want.agent_id, want.last,
                                 o_res.status, o_res.found, o_res.agent_id, o_res.last);
                end
            end
        end
    end

    function automatic ugnq_pkg::t_req req_of(logic [1:0] k, logic [15:0] x,
                                              logic [15:0] y, logic [15:0] rad,
                                              logic [31:0] id, logic [15:0] ty);
        ugnq_pkg::t_req r;
        r.req_type  = k;
        r.pos_x     = x;
        r.pos_y     = y;
        r.radius    = rad;
        r.entity_id = id;
        r.type_id   = ty;
        return r;
    endfunction

    // A small set of types keeps queries hitting; now and then a full-range one.
    function automatic logic [15:0] pick_type();
        case ($urandom_range(4))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFF;
            3: return 16'h00A5;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic ugnq_pkg::t_req random_req();
        int unsigned k, span_x, span_y;
        logic [15:0] x, y, rad;
        logic [31:0] id;
        k      = $urandom_range(99);
        span_x = (cfg_cols > MAX_COLS ? MAX_COLS : cfg_cols) * CELL_SIZE + 60;
        span_y = (cfg_rows > MAX_ROWS ? MAX_ROWS : cfg_rows) * CELL_SIZE + 60;
        x   = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(span_x));
        y   = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(span_y));
        rad = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(250));
        id  = {pick_type(), 16'($urandom())};
        if (k < 3)
            return req_of(ugnq_pkg::REQ_CLEAR, 16'($urandom()), 16'($urandom()),
                          16'($urandom()), $urandom(), 16'($urandom()));
        if (k < 5)
            return req_of(ugnq_pkg::REQ_RESERVED, 16'($urandom()), 16'($urandom()),
                          16'($urandom()), $urandom(), 16'($urandom()));
        if (k < 62)
            return req_of(ugnq_pkg::REQ_INSERT, x, y, 16'($urandom()), id,
                          16'($urandom()));
        return req_of(ugnq_pkg::REQ_QUERY, x, y, rad, $urandom(), pick_type());
    endfunction

    task automatic reg_write(input logic [2:0] addr, input logic [4:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= ($urandom() & 32'hFFFF_FFE0) | {27'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'(ugnq_pkg::REG_COLUMNS) * 3'd4) cfg_cols = val;
        else cfg_rows = val;
    endtask

    // Waits until every queued request is taken and every word has come,
    // then lets the block settle.
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || expected_words.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Filling a three by three block of cells with one type overfills the
    // cells and can give more than MAX_HITS matches for a covering query.
    task automatic push_burst();
        logic [15:0] ty;
        ty = pick_type();
        add_req(req_of(ugnq_pkg::REQ_CLEAR, 0, 0, 0, 0, 0));
        repeat (80)
            add_req(req_of(ugnq_pkg::REQ_INSERT, 16'($urandom_range(299)),
                           16'($urandom_range(299)), 16'($urandom()),
                           {ty, 16'($urandom())}, 16'($urandom())));
        add_req(req_of(ugnq_pkg::REQ_QUERY, 150, 150, 150, $urandom(), ty));
        add_req(req_of(ugnq_pkg::REQ_QUERY, 150, 150, 150, $urandom(), ~ty));
    endtask

    // Timeout guard.
    initial begin
        #500_000_000;
        $display("tb_uniform_grid_neighbor_query_top: FAIL");
        $finish;
    end

    initial begin
        int phase_cols[6] = '{16, 3, 0, 31, 1, 7};
        int phase_rows[6] = '{16, 5, 31, 0, 16, 9};
        int phase_idle[6] = '{0, 63, 0, 37, 63, 0};
        mismatches = 0;
        idle_pct   = 0;
        cfg_cols   = 5'd16;
        cfg_rows   = 5'd16;
        foreach (grid_fill[i]) grid_fill[i] = '0;
        foreach (grid_slot[i]) grid_slot[i] = '0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening on the reset-sized grid.
        add_req(req_of(ugnq_pkg::REQ_INSERT, 0, 0, 16'hFFFF, 32'h0000_0000, 0));
        add_req(req_of(ugnq_pkg::REQ_INSERT, 1599, 1599, 0, 32'hFFFF_FFFF, 16'hFFFF));
        add_req(req_of(ugnq_pkg::REQ_INSERT, 1600, 5, 0, 32'h0001_0001, 0));
        add_req(req_of(ugnq_pkg::REQ_INSERT, 5, 1600, 0, 32'h0001_0002, 0));
        add_req(req_of(ugnq_pkg::REQ_INSERT, 16'hFFFF, 16'hFFFF, 0, 32'h0001_0003, 0));
        for (int i = 0; i < 9; i++)   // the ninth finds the cell full
            add_req(req_of(ugnq_pkg::REQ_INSERT, 750, 420, 0, 32'h0001_0100 + i, 0));
        add_req(req_of(ugnq_pkg::REQ_QUERY, 0, 0, 0, 0, 16'h0000));
        add_req(req_of(ugnq_pkg::REQ_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF));
        add_req(req_of(ugnq_pkg::REQ_QUERY, 750, 420, 0, 0, 16'h0001));
        add_req(req_of(ugnq_pkg::REQ_QUERY, 750, 420, 16'hFFFF, 0, 16'h1234));
        add_req(req_of(ugnq_pkg::REQ_QUERY, 800, 800, 16'hFFFF, 0, 16'h0001));
        add_req(req_of(ugnq_pkg::REQ_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       32'hFFFF_FFFF, 16'hFFFF));
        add_req(req_of(ugnq_pkg::REQ_CLEAR, 0, 0, 0, 0, 0));
        add_req(req_of(ugnq_pkg::REQ_QUERY, 750, 420, 16'hFFFF, 0, 16'h0001));
        wait_quiet();

        for (int p = 0; p < 6; p++) begin
            reg_write(3'(ugnq_pkg::REG_COLUMNS) * 3'd4, 5'(phase_cols[p]));
            reg_write(3'(ugnq_pkg::REG_ROWS) * 3'd4, 5'(phase_rows[p]));
            idle_pct = phase_idle[p];
            if (p == 2) begin
                // Zero-sized grid: inserts land outside and queries find nothing.
                add_req(req_of(ugnq_pkg::REQ_INSERT, 0, 0, 0, 32'h0001_0000, 0));
                add_req(req_of(ugnq_pkg::REQ_QUERY, 0, 0, 16'hFFFF, 0, 16'h0001));
            end
            repeat (25) add_req(random_req());
            // The sender holds off here until the block has answered everything.
            wait_quiet();
            if (cfg_cols >= 3 && cfg_rows >= 3 && p != 4) push_burst();
            repeat (25) add_req(random_req());
            wait_quiet();
        end

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb_uniform_grid_neighbor_query_top: PASS");
        end else begin
            $display("tb_uniform_grid_neighbor_query_top: FAIL");
        end
        $finish;
    end

endmodule
